// ===== src/sesm_pkg.sv =====
// ----------------------------------------------------------------------------
// sesm_pkg
// Shared types and constants of the speech endpoint state machine: register
// indexes, reset values, phase codes and the configuration and result bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package sesm_pkg;

    localparam int unsigned POS_BITS_DEF = 24;
    localparam int unsigned SEG_W        = 24;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned ENERGY_W     = 32;
    localparam int unsigned ZCR_W        = 16;

    localparam logic [SEG_W-1:0] OUT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENERGY_HIGH = 3'd0,
        REG_ENERGY_LOW  = 3'd1,
        REG_ZCR_LOW     = 3'd2,
        REG_STAY_ENERGY = 3'd3,
        REG_STAY_ZCR    = 3'd4,
        REG_MIN_SILENCE = 3'd5,
        REG_MIN_VOICE   = 3'd6
    } t_reg_idx;

    localparam logic [ENERGY_W-1:0] RST_ENERGY_HIGH = 32'd655360;
    localparam logic [ENERGY_W-1:0] RST_ENERGY_LOW  = 32'd131072;
    localparam logic [ZCR_W-1:0]    RST_ZCR_LOW     = 16'd1280;
    localparam logic [ENERGY_W-1:0] RST_STAY_ENERGY = 32'd0;
    localparam logic [ZCR_W-1:0]    RST_STAY_ZCR    = 16'd0;
    localparam logic [7:0]          RST_MIN_SILENCE = 8'd6;
    localparam logic [15:0]         RST_MIN_VOICE   = 16'd15;

    typedef enum logic [3:0] {
        PH_SILENCE = 4'b0001,
        PH_TRANS   = 4'b0010,
        PH_VOICE   = 4'b0100,
        PH_OVER    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy_high;
        logic [ENERGY_W-1:0] energy_low;
        logic [ZCR_W-1:0]    zcr_low;
        logic [ENERGY_W-1:0] stay_energy;
        logic [ZCR_W-1:0]    stay_zcr;
        logic [7:0]          min_silence;
        logic [15:0]         min_voice;
    } t_cfg;

    typedef struct packed {
        logic [SEG_W-1:0] seg_begin;
        logic [SEG_W-1:0] seg_end;
        logic [SEG_W-1:0] seg_length;
    } t_seg;

endpackage

`default_nettype wire

// ===== src/sesm_cfg.sv =====
// ----------------------------------------------------------------------------
// sesm_cfg
// Configuration register file. Writes by index; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module sesm_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_we,
    input  wire logic [sesm_pkg::CFG_IDX_W-1:0]     i_index,
    input  wire logic [sesm_pkg::CFG_DATA_W-1:0]    i_data,
    output sesm_pkg::t_cfg                          o_cfg
);

    sesm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.energy_high <= sesm_pkg::RST_ENERGY_HIGH;
            r_cfg.energy_low  <= sesm_pkg::RST_ENERGY_LOW;
            r_cfg.zcr_low     <= sesm_pkg::RST_ZCR_LOW;
            r_cfg.stay_energy <= sesm_pkg::RST_STAY_ENERGY;
            r_cfg.stay_zcr    <= sesm_pkg::RST_STAY_ZCR;
            r_cfg.min_silence <= sesm_pkg::RST_MIN_SILENCE;
            r_cfg.min_voice   <= sesm_pkg::RST_MIN_VOICE;
        end else if (i_we) begin
            unique case (i_index)
                sesm_pkg::REG_ENERGY_HIGH: r_cfg.energy_high <= i_data;
                sesm_pkg::REG_ENERGY_LOW:  r_cfg.energy_low  <= i_data;
                sesm_pkg::REG_ZCR_LOW:     r_cfg.zcr_low     <= i_data[15:0];
                sesm_pkg::REG_STAY_ENERGY: r_cfg.stay_energy <= i_data;
                sesm_pkg::REG_STAY_ZCR:    r_cfg.stay_zcr    <= i_data[15:0];
                sesm_pkg::REG_MIN_SILENCE: r_cfg.min_silence <= i_data[7:0];
                sesm_pkg::REG_MIN_VOICE:   r_cfg.min_voice   <= i_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/sesm_fsm.sv =====
// ----------------------------------------------------------------------------
// sesm_fsm
// Endpoint state machine with position, voice and silence counters. Updates
// once per advanced item and flags a segment when the item meets the
// segment-over phase.
// ----------------------------------------------------------------------------
`default_nettype none

module sesm_fsm #(
    parameter int unsigned POS_BITS = sesm_pkg::POS_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_advance,
    input  wire logic [sesm_pkg::ENERGY_W-1:0]      i_energy,
    input  wire logic [sesm_pkg::ZCR_W-1:0]         i_zcr,
    input  wire sesm_pkg::t_cfg                     i_cfg,
    output logic                                    o_emit,
    output sesm_pkg::t_seg                          o_seg
);

    localparam int unsigned CMP_W = (POS_BITS > 16) ? POS_BITS : 16;
    localparam int unsigned EXT_W = (POS_BITS > sesm_pkg::SEG_W) ? POS_BITS : sesm_pkg::SEG_W;

    sesm_pkg::t_phase    r_phase, n_phase;
    logic [POS_BITS-1:0] r_position, n_position;
    logic [POS_BITS-1:0] r_voice_len, n_voice_len;
    logic [POS_BITS-1:0] r_silence_len, n_silence_len;
    logic [POS_BITS-1:0] r_start_pos, n_start_pos;
    logic [POS_BITS-1:0] r_stop_pos, n_stop_pos;

    logic [POS_BITS-1:0] w_pos_inc, w_voice_inc, w_sil_inc;
    logic [POS_BITS:0]   w_begin_diff, w_end_sum;
    logic [POS_BITS-1:0] w_begin, w_end;
    logic                w_hi, w_lo, w_stay;
    logic [EXT_W-1:0]    w_ext_begin, w_ext_end, w_ext_len;

    assign w_pos_inc   = (r_position == '1) ? r_position : r_position + 1'b1;
    assign w_voice_inc = (r_voice_len == '1) ? r_voice_len : r_voice_len + 1'b1;
    assign w_sil_inc   = (r_silence_len == '1) ? r_silence_len : r_silence_len + 1'b1;

    assign w_begin_diff = {1'b0, r_position} - {1'b0, r_voice_len} - 1'b1;
    assign w_begin      = w_begin_diff[POS_BITS] ? '0 : w_begin_diff[POS_BITS-1:0];
    assign w_end_sum    = {1'b0, r_start_pos} + {1'b0, r_voice_len};
    assign w_end        = w_end_sum[POS_BITS] ? '1 : w_end_sum[POS_BITS-1:0];

    assign w_hi   = i_energy > i_cfg.energy_high;
    assign w_lo   = (i_energy > i_cfg.energy_low) || (i_zcr > i_cfg.zcr_low);
    assign w_stay = (i_energy > i_cfg.stay_energy) || (i_zcr > i_cfg.stay_zcr);

    always_comb begin
        n_phase       = r_phase;
        n_voice_len   = r_voice_len;
        n_silence_len = r_silence_len;
        n_start_pos   = r_start_pos;
        n_stop_pos    = r_stop_pos;
        n_position    = w_pos_inc;
        unique case (r_phase)
            sesm_pkg::PH_SILENCE, sesm_pkg::PH_TRANS: begin
                if (w_hi) begin
                    n_start_pos   = w_begin;
                    n_phase       = sesm_pkg::PH_VOICE;
                    n_voice_len   = w_voice_inc;
                    n_silence_len = '0;
                end else if (w_lo) begin
                    n_phase     = sesm_pkg::PH_TRANS;
                    n_voice_len = w_voice_inc;
                end else begin
                    n_phase     = sesm_pkg::PH_SILENCE;
                    n_voice_len = '0;
                end
            end
            sesm_pkg::PH_VOICE: begin
                if (w_stay) begin
                    n_voice_len = w_voice_inc;
                end else begin
                    n_silence_len = w_sil_inc;
                    if (CMP_W'(w_sil_inc) < CMP_W'(i_cfg.min_silence)) begin
                        n_voice_len = w_voice_inc;
                    end else if (CMP_W'(r_voice_len) < CMP_W'(i_cfg.min_voice)) begin
                        n_phase       = sesm_pkg::PH_SILENCE;
                        n_silence_len = '0;
                        n_voice_len   = '0;
                    end else begin
                        n_phase    = sesm_pkg::PH_OVER;
                        n_stop_pos = w_end;
                    end
                end
            end
            sesm_pkg::PH_OVER: begin
                n_phase       = sesm_pkg::PH_SILENCE;
                n_voice_len   = '0;
                n_silence_len = '0;
            end
            default: begin
                n_phase = sesm_pkg::PH_SILENCE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sesm_pkg::PH_SILENCE;
            r_position    <= '0;
            r_voice_len   <= '0;
            r_silence_len <= '0;
            r_start_pos   <= '0;
            r_stop_pos    <= '0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_voice_len   <= n_voice_len;
            r_silence_len <= n_silence_len;
            r_start_pos   <= n_start_pos;
            r_stop_pos    <= n_stop_pos;
        end
    end

    assign w_ext_begin = EXT_W'(r_start_pos);
    assign w_ext_end   = EXT_W'(r_stop_pos);
    assign w_ext_len   = EXT_W'(r_voice_len);

    assign o_emit = (r_phase == sesm_pkg::PH_OVER);
    assign o_seg.seg_begin  = (w_ext_begin > EXT_W'(sesm_pkg::OUT_MAX)) ?
                              sesm_pkg::OUT_MAX : w_ext_begin[sesm_pkg::SEG_W-1:0];
    assign o_seg.seg_end    = (w_ext_end > EXT_W'(sesm_pkg::OUT_MAX)) ?
                              sesm_pkg::OUT_MAX : w_ext_end[sesm_pkg::SEG_W-1:0];
    assign o_seg.seg_length = (w_ext_len > EXT_W'(sesm_pkg::OUT_MAX)) ?
                              sesm_pkg::OUT_MAX : w_ext_len[sesm_pkg::SEG_W-1:0];

endmodule

`default_nettype wire

// ===== src/speech_endpoint_state_machine.sv =====
// ----------------------------------------------------------------------------
// speech_endpoint_state_machine
// Double-threshold speech endpoint detector: takes one energy/ZCR item per
// analysis position and reports begin, end and length of each voice segment.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_stall   i_frame_energy, i_frame_zcr
//   output    out        o_out_valid / i_out_stall o_seg_begin, o_seg_end, o_seg_length
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item is taken into an input register and processed as the state machine
// advances, so one item per cycle is sustained unless the result register is
// stalled; a segment is presented on the output once the item that follows
// its end has left the input register. The result register loads in the
// same cycle as the state update. Reset is synchronous and clears the phase,
// counters and both valid flags. An item that yields a segment waits in the
// input register while the result register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module speech_endpoint_state_machine #(
    parameter int unsigned POS_BITS = sesm_pkg::POS_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sesm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sesm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [sesm_pkg::ENERGY_W-1:0]      i_frame_energy,
    input  wire logic [sesm_pkg::ZCR_W-1:0]         i_frame_zcr,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [sesm_pkg::SEG_W-1:0]              o_seg_begin,
    output logic [sesm_pkg::SEG_W-1:0]              o_seg_end,
    output logic [sesm_pkg::SEG_W-1:0]              o_seg_length
);

    sesm_pkg::t_cfg w_cfg;
    sesm_pkg::t_seg w_seg, r_seg;

    logic                          r_in_valid;
    logic [sesm_pkg::ENERGY_W-1:0] r_energy;
    logic [sesm_pkg::ZCR_W-1:0]    r_zcr;
    logic                          r_out_valid;
    logic                          w_emit, w_out_free, w_advance, w_accept;

    sesm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    sesm_fsm #(
        .POS_BITS (POS_BITS)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_energy  (r_energy),
        .i_zcr     (r_zcr),
        .i_cfg     (w_cfg),
        .o_emit    (w_emit),
        .o_seg     (w_seg)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_energy <= i_frame_energy;
            r_zcr    <= i_frame_zcr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_seg <= w_seg;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_seg_begin  = r_seg.seg_begin;
    assign o_seg_end    = r_seg.seg_end;
    assign o_seg_length = r_seg.seg_length;

endmodule

`default_nettype wire

// ===== src/sesm_checker.sv =====
// ----------------------------------------------------------------------------
// sesm_checker
// Port-level assertions for the speech endpoint state machine, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sesm_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_in_stall,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [sesm_pkg::SEG_W-1:0]     o_seg_begin,
    input  wire logic [sesm_pkg::SEG_W-1:0]     o_seg_end,
    input  wire logic [sesm_pkg::SEG_W-1:0]     o_seg_length
);

    // Reset leaves no segment pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("segment valid after reset");

    // A segment never ends before it begins.
    a_end_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_seg_end >= o_seg_begin))
        else $error("segment end before begin");

    // The span between begin and end never exceeds the reported length.
    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_seg_end - o_seg_begin) <= o_seg_length))
        else $error("segment span larger than length");

    // The input stalls only behind a segment that is itself stalled.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled segment");

    // A stalled segment holds its values.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_seg_begin) && $stable(o_seg_end)
             && $stable(o_seg_length)))
        else $error("stalled segment changed");

endmodule

bind speech_endpoint_state_machine sesm_checker u_sesm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_seg_begin  (o_seg_begin),
    .o_seg_end    (o_seg_end),
    .o_seg_length (o_seg_length)
);

`default_nettype wire

// ===== verif/tb_speech_endpoint_state_machine.sv =====
// ----------------------------------------------------------------------------
// tb_speech_endpoint_state_machine
// Self-checking testbench for the speech endpoint detector. A behavioral
// predictor tracks phase, counters and registers for every accepted item and
// queues the expected segments. A checker compares each result field by field.
// Directed tests hit the threshold edges, the clamp of the segment begin, the
// silence bridge and the zero minimums. Random phases then stream segments,
// some broken, under many register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_speech_endpoint_state_machine;

    localparam logic [sesm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_FRAMES = 600;
    localparam int RANDOM_FRAME_CAP = 2500;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [sesm_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sesm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [sesm_pkg::ENERGY_W-1:0]   i_frame_energy = '0;
    logic [sesm_pkg::ZCR_W-1:0]      i_frame_zcr = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [sesm_pkg::SEG_W-1:0]      o_seg_begin;
    logic [sesm_pkg::SEG_W-1:0]      o_seg_end;
    logic [sesm_pkg::SEG_W-1:0]      o_seg_length;

    speech_endpoint_state_machine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_energy (i_frame_energy),
        .i_frame_zcr    (i_frame_zcr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seg_begin    (o_seg_begin),
        .o_seg_end      (o_seg_end),
        .o_seg_length   (o_seg_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sesm_pkg::t_cfg   cfg;
    sesm_pkg::t_phase det_phase;
    logic [23:0]      frame_pos;
    logic [23:0]      voice_count;
    logic [23:0]      quiet_count;
    logic [23:0]      seg_start;
    logic [23:0]      seg_stop;
    sesm_pkg::t_seg   pending_segments[$];

    int frames_sent = 0;
    int segments_checked = 0;
    int mismatches = 0;
    int settings_used = 0;
    int cycle_count = 0;
    bit gap_enable = 1'b1;
    bit stall_enable = 1'b1;
    int stall_left = 0;
    int stall_roll;

    function automatic logic [23:0] bump(logic [23:0] v);
        return (v == '1) ? v : v + 24'd1;
    endfunction

    function automatic void detect_step(logic [31:0] energy, logic [15:0] zcr);
        logic [24:0]    stop_sum;
        sesm_pkg::t_seg seg;
        case (det_phase)
            sesm_pkg::PH_SILENCE, sesm_pkg::PH_TRANS: begin
                if (energy > cfg.energy_high) begin
                    if ({1'b0, frame_pos} >= {1'b0, voice_count} + 25'd1) begin
                        seg_start = frame_pos - voice_count - 24'd1;
                    end else begin
                        seg_start = '0;
                    end
                    det_phase = sesm_pkg::PH_VOICE;
                    voice_count = bump(voice_count);
                    quiet_count = '0;
                end else if (energy > cfg.energy_low || zcr > cfg.zcr_low) begin
                    det_phase = sesm_pkg::PH_TRANS;
                    voice_count = bump(voice_count);
                end else begin
                    det_phase = sesm_pkg::PH_SILENCE;
                    voice_count = '0;
                end
            end
            sesm_pkg::PH_VOICE: begin
                if (energy > cfg.stay_energy || zcr > cfg.stay_zcr) begin
                    voice_count = bump(voice_count);
                end else begin
                    quiet_count = bump(quiet_count);
                    if (quiet_count < cfg.min_silence) begin
                        voice_count = bump(voice_count);
                    end else if (voice_count < cfg.min_voice) begin
                        det_phase = sesm_pkg::PH_SILENCE;
                        quiet_count = '0;
                        voice_count = '0;
                    end else begin
                        stop_sum = {1'b0, seg_start} + {1'b0, voice_count};
                        det_phase = sesm_pkg::PH_OVER;
                        seg_stop = stop_sum[24] ? '1 : stop_sum[23:0];
                    end
                end
            end
            default: begin
                seg.seg_begin = seg_start;
                seg.seg_end = seg_stop;
                seg.seg_length = voice_count;
                pending_segments = {pending_segments, seg};
                det_phase = sesm_pkg::PH_SILENCE;
                voice_count = '0;
                quiet_count = '0;
            end
        endcase
        frame_pos = bump(frame_pos);
    endfunction

    function automatic logic [31:0] rand_range32(logic [31:0] lo, logic [31:0] hi);
        logic [32:0] span;
        logic [32:0] draw;
        span = {1'b0, hi} - {1'b0, lo} + 33'd1;
        draw = {1'b0, $urandom} % span;
        return lo + draw[31:0];
    endfunction

    function automatic logic [31:0] pick_above(logic [31:0] th, logic [31:0] top);
        if (th >= top) begin
            return top;
        end
        return rand_range32(th + 32'd1, top);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (!gap_enable || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else begin
            stall_roll = $urandom_range(99, 0);
            if (!stall_enable || stall_roll < 55) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(6, 1);
            end else if (stall_roll < 92) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(2, 0);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(25, 8);
            end
        end
    end

    always @(posedge i_clk) begin
        sesm_pkg::t_seg want;
        sesm_pkg::t_seg got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.seg_begin = o_seg_begin;
            got.seg_end = o_seg_end;
            got.seg_length = o_seg_length;
            if (pending_segments.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected segment begin %0d end %0d length %0d",
                         $time, got.seg_begin, got.seg_end, got.seg_length);
            end else begin
                want = pending_segments.pop_front();
                segments_checked++;
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: segment mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, want.seg_begin, want.seg_end, want.seg_length,
                             got.seg_begin, got.seg_end, got.seg_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[speech_endpoint_state_machine] ERROR");
            $finish;
        end
    end

    task automatic send_frame(input logic [31:0] energy, input logic [15:0] zcr);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_frame_energy <= energy;
        i_frame_zcr <= zcr;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        detect_step(energy, zcr);
        frames_sent++;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_segments.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sesm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        hold_until_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            sesm_pkg::REG_ENERGY_HIGH: cfg.energy_high = data;
            sesm_pkg::REG_ENERGY_LOW:  cfg.energy_low = data;
            sesm_pkg::REG_ZCR_LOW:     cfg.zcr_low = data[15:0];
            sesm_pkg::REG_STAY_ENERGY: cfg.stay_energy = data;
            sesm_pkg::REG_STAY_ZCR:    cfg.stay_zcr = data[15:0];
            sesm_pkg::REG_MIN_SILENCE: cfg.min_silence = data[7:0];
            sesm_pkg::REG_MIN_VOICE:   cfg.min_voice = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_quiet();
        send_frame(rand_range32(0, cfg.stay_energy),
                   16'(rand_range32(0, {16'h0, cfg.stay_zcr})));
    endtask

    // A segment: leading silence, optional transition, a loud start, a body that
    // may hold short quiet runs, then enough quiet to close it and one more item
    // that releases the result. Broken segments stop inside the closing run.
    task automatic send_segment(input bit broken);
        int          eff_sil;
        int          lim;
        int          body;
        int          n;
        logic [31:0] floor_e;
        eff_sil = (cfg.min_silence == 0) ? 1 : int'(cfg.min_silence);
        lim = (cfg.min_voice > 40) ? 40 : int'(cfg.min_voice);
        floor_e = (cfg.energy_low < cfg.energy_high) ? cfg.energy_low : cfg.energy_high;
        repeat ($urandom_range(2, 0)) begin
            send_frame(rand_range32(0, floor_e), 16'(rand_range32(0, {16'h0, cfg.zcr_low})));
        end
        repeat ($urandom_range(3, 0)) begin
            if (cfg.energy_low < cfg.energy_high && $urandom_range(1, 0) == 1) begin
                send_frame(rand_range32(cfg.energy_low + 32'd1, cfg.energy_high),
                           16'($urandom));
            end else begin
                send_frame(rand_range32(0, cfg.energy_high),
                           16'(pick_above({16'h0, cfg.zcr_low}, 32'h0000_FFFF)));
            end
        end
        send_frame(pick_above(cfg.energy_high, '1), 16'($urandom));
        body = $urandom_range(lim + 3, 0);
        for (int k = 0; k < body; k++) begin
            if (eff_sil > 1 && $urandom_range(7, 0) == 0) begin
                repeat ($urandom_range(eff_sil - 1, 1)) send_quiet();
            end else if ($urandom_range(1, 0) == 1) begin
                send_frame(pick_above(cfg.stay_energy, '1), 16'($urandom));
            end else begin
                send_frame($urandom, 16'(pick_above({16'h0, cfg.stay_zcr}, 32'h0000_FFFF)));
            end
        end
        n = broken ? $urandom_range(eff_sil - 1, 0) : eff_sil;
        repeat (n) send_quiet();
        if (!broken) begin
            send_frame($urandom, 16'($urandom));
        end
    endtask

    task automatic program_setting(input int k);
        logic [31:0] eh;
        logic [31:0] el;
        logic [31:0] se;
        logic [31:0] junk;
        logic [15:0] zl;
        logic [15:0] sz;
        logic [15:0] mv;
        logic [7:0]  ms;
        junk = $urandom;
        case (k)
            0: begin
                eh = sesm_pkg::RST_ENERGY_HIGH;
                el = sesm_pkg::RST_ENERGY_LOW;
                zl = sesm_pkg::RST_ZCR_LOW;
                se = sesm_pkg::RST_STAY_ENERGY;
                sz = sesm_pkg::RST_STAY_ZCR;
                ms = sesm_pkg::RST_MIN_SILENCE;
                mv = sesm_pkg::RST_MIN_VOICE;
            end
            1: begin
                eh = '0; el = '0; zl = '0; se = '0; sz = '0; ms = '0; mv = '0;
            end
            2: begin
                eh = '1; el = '1; zl = '1; se = '1; sz = '1; ms = '1; mv = '1;
            end
            3: begin
                eh = 32'h0004_0000; el = 32'h0001_0000; zl = 16'h0200;
                se = 32'h0000_8000; sz = 16'h0080; ms = 8'hFF; mv = 16'd1;
            end
            default: begin
                el = rand_range32(0, 32'h0010_0000);
                eh = el + rand_range32(0, 32'h0010_0000);
                zl = 16'($urandom);
                se = rand_range32(0, eh);
                sz = 16'($urandom_range(2048, 0));
                if ($urandom_range(4, 0) == 0) begin
                    eh = $urandom;
                    el = $urandom;
                    se = $urandom;
                    sz = 16'($urandom);
                end
                ms = 8'($urandom_range(8, 0));
                mv = 16'($urandom_range(20, 0));
            end
        endcase
        write_reg(sesm_pkg::REG_ENERGY_HIGH, eh);
        write_reg(sesm_pkg::REG_ENERGY_LOW, el);
        write_reg(sesm_pkg::REG_ZCR_LOW, {junk[15:0], zl});
        write_reg(sesm_pkg::REG_STAY_ENERGY, se);
        write_reg(sesm_pkg::REG_STAY_ZCR, {junk[31:16], sz});
        write_reg(sesm_pkg::REG_MIN_SILENCE, {junk[23:0], ms});
        write_reg(sesm_pkg::REG_MIN_VOICE, {junk[31:16], mv});
        settings_used++;
    endtask

    // The first item lands on position zero, so the begin has nothing to
    // subtract from and must clamp at zero.
    task automatic test_begin_clamp();
        write_reg(sesm_pkg::REG_MIN_VOICE, 32'd2);
        write_reg(sesm_pkg::REG_MIN_SILENCE, 32'd1);
        send_frame(32'hFFFF_FFFF, 16'h0000);
        send_frame(32'h0000_0000, 16'h0001);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'hFFFF);
    endtask

    task automatic test_threshold_edges();
        send_frame(sesm_pkg::RST_ENERGY_LOW, sesm_pkg::RST_ZCR_LOW);
        send_frame(sesm_pkg::RST_ENERGY_HIGH, 16'h0000);
        send_frame(32'h0000_0000, sesm_pkg::RST_ZCR_LOW + 16'd1);
        send_frame(sesm_pkg::RST_ENERGY_HIGH + 32'd1, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(sesm_pkg::RST_ENERGY_HIGH + 32'd1, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
    endtask

    task automatic test_silence_bridge();
        write_reg(sesm_pkg::REG_MIN_SILENCE, 32'd3);
        write_reg(sesm_pkg::REG_STAY_ENERGY, 32'h0001_0000);
        write_reg(sesm_pkg::REG_STAY_ZCR, 32'h0000_0100);
        send_frame(32'hFFFF_FFFF, 16'h0000);
        send_frame(32'h0001_0000, 16'h0100);
        send_frame(32'h0001_0001, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
    endtask

    task automatic test_zero_minimums();
        write_reg(sesm_pkg::REG_MIN_SILENCE, 32'd0);
        write_reg(sesm_pkg::REG_MIN_VOICE, 32'd0);
        write_reg(sesm_pkg::REG_STAY_ENERGY, 32'd0);
        write_reg(sesm_pkg::REG_STAY_ZCR, 32'd0);
        send_frame(32'hFFFF_FFFF, 16'hFFFF);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        hold_until_drained();
    endtask

    task automatic test_unused_register();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_frame(sesm_pkg::RST_ENERGY_HIGH + 32'd1, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'h0000_0000, 16'h0000);
    endtask

    task automatic test_random_segments(input int first_frame);
        int k;
        int phase_start;
        int target;
        int roll;
        k = 0;
        while ((frames_sent - first_frame < RANDOM_FRAMES || segments_checked < 40)
               && frames_sent - first_frame < RANDOM_FRAME_CAP) begin
            program_setting(k);
            gap_enable = ($urandom_range(3, 0) != 0);
            stall_enable = ($urandom_range(3, 0) != 0);
            phase_start = frames_sent;
            target = (k == 2) ? 40 : 90;
            while (frames_sent - phase_start < target) begin
                roll = $urandom_range(99, 0);
                if (k == 2 || roll < 12) begin
                    send_frame($urandom, 16'($urandom));
                end else begin
                    send_segment(roll < 22);
                    if ($urandom_range(9, 0) == 0) begin
                        hold_until_drained();
                    end
                end
            end
            k++;
        end
    endtask

    initial begin
        int directed_frames;
        cfg.energy_high = sesm_pkg::RST_ENERGY_HIGH;
        cfg.energy_low = sesm_pkg::RST_ENERGY_LOW;
        cfg.zcr_low = sesm_pkg::RST_ZCR_LOW;
        cfg.stay_energy = sesm_pkg::RST_STAY_ENERGY;
        cfg.stay_zcr = sesm_pkg::RST_STAY_ZCR;
        cfg.min_silence = sesm_pkg::RST_MIN_SILENCE;
        cfg.min_voice = sesm_pkg::RST_MIN_VOICE;
        det_phase = sesm_pkg::PH_SILENCE;
        frame_pos = '0;
        voice_count = '0;
        quiet_count = '0;
        seg_start = '0;
        seg_stop = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_begin_clamp();
        test_threshold_edges();
        test_silence_bridge();
        test_zero_minimums();
        test_unused_register();
        directed_frames = frames_sent;
        test_random_segments(directed_frames);

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        mismatches += pending_segments.size();
        $display("Sent %0d frames (%0d directed) over %0d register settings;",
                 frames_sent, directed_frames, settings_used);
        $display("%0d segments checked.", segments_checked);
        if (mismatches == 0) begin
            $display("[speech_endpoint_state_machine] OK");
        end else begin
            $display("[speech_endpoint_state_machine] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sesm_pkg.sv
src/sesm_cfg.sv
src/sesm_fsm.sv
src/speech_endpoint_state_machine.sv
src/sesm_checker.sv
verif/tb_speech_endpoint_state_machine.sv
